### sv/pitc_pkg.sv
// Shared types, widths and result codes for the point-in-tetrahedron classifier.
package pitc_pkg;

  localparam int COORD_BITS = 16;
  localparam int VTX_BITS   = 3 * COORD_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS + 1;
  localparam int DET_BITS   = 3 * DIFF_BITS + 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DET_BITS-1:0]   det_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // what the front hands to the back: vertex hit code or geometric query
  typedef struct packed {
    logic   hit;
    logic [3:0] hit_code;
    point_t p;
  } item_t;

  typedef enum logic [3:0] {
    LOC_OUTSIDE = 4'd0,
    LOC_INSIDE  = 4'd1,
    LOC_VTX0    = 4'd2,
    LOC_VTX1    = 4'd3,
    LOC_VTX2    = 4'd4,
    LOC_VTX3    = 4'd5,
    LOC_EDGE0   = 4'd6,
    LOC_EDGE1   = 4'd7,
    LOC_EDGE2   = 4'd8,
    LOC_EDGE3   = 4'd9,
    LOC_EDGE4   = 4'd10,
    LOC_EDGE5   = 4'd11,
    LOC_FACE0   = 4'd12,
    LOC_FACE1   = 4'd13,
    LOC_FACE2   = 4'd14,
    LOC_FACE3   = 4'd15
  } loc_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VTX0 = 2'd0,
    REG_VTX1 = 2'd1,
    REG_VTX2 = 2'd2,
    REG_VTX3 = 2'd3
  } reg_idx_t;

  function automatic point_t unpack_vtx(input logic [VTX_BITS-1:0] r);
    point_t p;
    p.x = r[COORD_BITS-1:0];
    p.y = r[2*COORD_BITS-1:COORD_BITS];
    p.z = r[3*COORD_BITS-1:2*COORD_BITS];
    return p;
  endfunction

endpackage

### sv/point_in_tetrahedron_classify.sv
// Top level: vertex registers, front check, queue and determinant back end.
// Accepts one query point per cycle (busy stays low) and gives one location
// code per point, in order, after the front vertex compare register, the queue,
// and the back determinant pipeline (differences, 2x2 minors, row products,
// sum, decode).
// The result strobe is not held off; vertex writes belong in idle periods.
module point_in_tetrahedron_classify import pitc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  output logic                    done,
  output logic [3:0]              location,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VTX_BITS-1:0]     cfg_data
);

  logic [VTX_BITS-1:0] vertex_0, vertex_1, vertex_2, vertex_3;
  point_t v0, v1, v2, v3, p;
  logic   f_valid, q_valid;
  item_t  f_item, q_item;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_0 <= '0;
      vertex_1 <= '0;
      vertex_2 <= '0;
      vertex_3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VTX0: vertex_0 <= cfg_data;
        REG_VTX1: vertex_1 <= cfg_data;
        REG_VTX2: vertex_2 <= cfg_data;
        REG_VTX3: vertex_3 <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign v0 = unpack_vtx(vertex_0);
  assign v1 = unpack_vtx(vertex_1);
  assign v2 = unpack_vtx(vertex_2);
  assign v3 = unpack_vtx(vertex_3);
  assign p.x = point_x;
  assign p.y = point_y;
  assign p.z = point_z;

  pitc_front u_front (
    .clk, .rst, .in_valid(start && !busy), .in_p(p),
    .v0, .v1, .v2, .v3, .out_valid(f_valid), .out_item(f_item)
  );

  pitc_queue u_queue (
    .clk, .rst, .wr_en(f_valid), .wr_item(f_item),
    .rd_en(1'b1), .rd_valid(q_valid), .rd_item(q_item)
  );

  pitc_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_item(q_item),
    .v0, .v1, .v2, .v3, .out_valid(done), .out_loc(location)
  );

endmodule

### sv/pitc_front.sv
// Front: vertex-equality check and item formation.
module pitc_front import pitc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  point_t in_p,
  input  point_t v0,
  input  point_t v1,
  input  point_t v2,
  input  point_t v3,
  output logic   out_valid,
  output item_t  out_item
);

  item_t item_next;

  always_comb begin
    item_next.p        = in_p;
    item_next.hit      = 1'b1;
    item_next.hit_code = LOC_VTX0;
    priority if (in_p == v0) item_next.hit_code = LOC_VTX0;
    else if (in_p == v1) item_next.hit_code = LOC_VTX1;
    else if (in_p == v2) item_next.hit_code = LOC_VTX2;
    else if (in_p == v3) item_next.hit_code = LOC_VTX3;
    else item_next.hit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= item_next;
  end

endmodule

### sv/pitc_queue.sv
// Short FIFO between the front and the back.
module pitc_queue import pitc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  input  logic  rd_en,
  output logic  rd_valid,
  output item_t rd_item
);

  item_t mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wp, rp;
  logic [Q_PTR_BITS:0]   cnt;

  assign rd_valid = (cnt != '0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en && rd_valid) rp <= rp + 1'b1;
      cnt <= cnt + (Q_PTR_BITS+1)'(wr_en) - (Q_PTR_BITS+1)'(rd_en && rd_valid);
    end
    if (wr_en) mem[wp] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && !rd_en && cnt == (Q_PTR_BITS+1)'(Q_DEPTH)))
    else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= (Q_PTR_BITS+1)'(Q_DEPTH))
    else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (rd_en && rd_valid && !wr_en) |=> cnt == $past(cnt) - 1'b1)
    else $error("pop did not lower count");
`endif

endmodule

### sv/pitc_back.sv
// Back: orientation determinants over a pipeline, then sign/zero decode.
module pitc_back import pitc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  item_t  in_item,
  input  point_t v0,
  input  point_t v1,
  input  point_t v2,
  input  point_t v3,
  output logic   out_valid,
  output logic [3:0] out_loc
);

  // stage 1: differences of each vertex to the point
  diff_t dx [4], dy [4], dz [4];
  logic  s1_valid, s1_hit;
  logic [3:0] s1_code;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
    s1_hit  <= in_item.hit;
    s1_code <= in_item.hit_code;
    dx[0] <= diff_t'(v0.x) - diff_t'(in_item.p.x);
    dy[0] <= diff_t'(v0.y) - diff_t'(in_item.p.y);
    dz[0] <= diff_t'(v0.z) - diff_t'(in_item.p.z);
    dx[1] <= diff_t'(v1.x) - diff_t'(in_item.p.x);
    dy[1] <= diff_t'(v1.y) - diff_t'(in_item.p.y);
    dz[1] <= diff_t'(v1.z) - diff_t'(in_item.p.z);
    dx[2] <= diff_t'(v2.x) - diff_t'(in_item.p.x);
    dy[2] <= diff_t'(v2.y) - diff_t'(in_item.p.y);
    dz[2] <= diff_t'(v2.z) - diff_t'(in_item.p.z);
    dx[3] <= diff_t'(v3.x) - diff_t'(in_item.p.x);
    dy[3] <= diff_t'(v3.y) - diff_t'(in_item.p.y);
    dz[3] <= diff_t'(v3.z) - diff_t'(in_item.p.z);
  end

  // faces as (a,b,c) vertex triples
  localparam int FA [4] = '{0, 0, 0, 1};
  localparam int FB [4] = '{2, 1, 3, 2};
  localparam int FC [4] = '{1, 3, 2, 3};

  // stage 2: 2x2 minors; stage 3: products with the first row; stage 4: sum
  prod_t m0 [4], m1 [4], m2 [4];
  diff_t ax [4], ay [4], az [4];
  det_t  t0 [4], t1 [4], t2 [4];
  det_t  det [4];
  logic  s2_valid, s3_valid, s4_valid;
  logic  s2_hit, s3_hit, s4_hit;
  logic [3:0] s2_code, s3_code, s4_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s2_hit <= s1_hit; s2_code <= s1_code;
    s3_hit <= s2_hit; s3_code <= s2_code;
    s4_hit <= s3_hit; s4_code <= s3_code;
    for (int f = 0; f < 4; f++) begin
      m0[f] <= prod_t'(dy[FB[f]]) * prod_t'(dz[FC[f]])
             - prod_t'(dz[FB[f]]) * prod_t'(dy[FC[f]]);
      m1[f] <= prod_t'(dx[FB[f]]) * prod_t'(dz[FC[f]])
             - prod_t'(dz[FB[f]]) * prod_t'(dx[FC[f]]);
      m2[f] <= prod_t'(dx[FB[f]]) * prod_t'(dy[FC[f]])
             - prod_t'(dy[FB[f]]) * prod_t'(dx[FC[f]]);
      ax[f] <= dx[FA[f]];
      ay[f] <= dy[FA[f]];
      az[f] <= dz[FA[f]];
      t0[f] <= det_t'(ax[f]) * det_t'(m0[f]);
      t1[f] <= det_t'(ay[f]) * det_t'(m1[f]);
      t2[f] <= det_t'(az[f]) * det_t'(m2[f]);
      det[f] <= t0[f] - t1[f] + t2[f];
    end
  end

  logic [3:0] z, neg, pos;
  logic [3:0] loc;

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      z[f]   = (det[f] == '0);
      neg[f] = det[f][DET_BITS-1];
      pos[f] = !z[f] && !neg[f];
    end
    priority if (s4_hit)           loc = s4_code;
    else if (|neg && |pos)         loc = LOC_OUTSIDE;
    else if (z[0] && z[2])         loc = LOC_EDGE0;
    else if (z[0] && z[3])         loc = LOC_EDGE1;
    else if (z[0] && z[1])         loc = LOC_EDGE2;
    else if (z[1] && z[3])         loc = LOC_EDGE3;
    else if (z[1] && z[2])         loc = LOC_EDGE4;
    else if (z[2] && z[3])         loc = LOC_EDGE5;
    else if (z[0])                 loc = LOC_FACE0;
    else if (z[1])                 loc = LOC_FACE1;
    else if (z[2])                 loc = LOC_FACE2;
    else if (z[3])                 loc = LOC_FACE3;
    else                           loc = LOC_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= s4_valid;
    out_loc <= loc;
  end

endmodule

### bench/pitc_checker.sv
// Checker: predicts the location code of every accepted point and compares results.
`timescale 1ns / 1ps
module pitc_checker import pitc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                    done,
  input  logic [3:0]              location,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VTX_BITS-1:0]     cfg_data,
  output int                      fail_count,
  output int                      pending
);

  logic [VTX_BITS-1:0] vtx_reg [4];
  loc_t loc_q[$];

  function automatic longint orient3(point_t a, point_t b, point_t c, point_t d);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    ax = longint'(a.x) - d.x; ay = longint'(a.y) - d.y; az = longint'(a.z) - d.z;
    bx = longint'(b.x) - d.x; by = longint'(b.y) - d.y; bz = longint'(b.z) - d.z;
    cx = longint'(c.x) - d.x; cy = longint'(c.y) - d.y; cz = longint'(c.z) - d.z;
    return ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx)
         + az * (bx * cy - by * cx);
  endfunction

  function automatic loc_t locate(point_t p);
    point_t t [4];
    longint f [4];
    logic z0, z1, z2, z3, nn, np;
    for (int k = 0; k < 4; k++) begin
      t[k].x = vtx_reg[k][COORD_BITS-1:0];
      t[k].y = vtx_reg[k][2*COORD_BITS-1:COORD_BITS];
      t[k].z = vtx_reg[k][3*COORD_BITS-1:2*COORD_BITS];
    end
    for (int k = 0; k < 4; k++)
      if (p == t[k]) return loc_t'(LOC_VTX0 + k);
    f[0] = orient3(t[0], t[2], t[1], p);
    f[1] = orient3(t[0], t[1], t[3], p);
    f[2] = orient3(t[0], t[3], t[2], p);
    f[3] = orient3(t[1], t[2], t[3], p);
    nn = f[0] >= 0 && f[1] >= 0 && f[2] >= 0 && f[3] >= 0;
    np = f[0] <= 0 && f[1] <= 0 && f[2] <= 0 && f[3] <= 0;
    if (!nn && !np) return LOC_OUTSIDE;
    z0 = f[0] == 0; z1 = f[1] == 0; z2 = f[2] == 0; z3 = f[3] == 0;
    if (z0 && z2) return LOC_EDGE0;
    if (z0 && z3) return LOC_EDGE1;
    if (z0 && z1) return LOC_EDGE2;
    if (z1 && z3) return LOC_EDGE3;
    if (z1 && z2) return LOC_EDGE4;
    if (z2 && z3) return LOC_EDGE5;
    if (z0) return LOC_FACE0;
    if (z1) return LOC_FACE1;
    if (z2) return LOC_FACE2;
    if (z3) return LOC_FACE3;
    return LOC_INSIDE;
  endfunction

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = loc_q.size();

  always @(posedge clk) begin
    point_t p;
    loc_t want;
    if (rst) begin
      for (int k = 0; k < 4; k++) vtx_reg[k] <= '0;
      loc_q.delete();
    end else begin
      // result first: a point taken this edge cannot finish on the same edge
      if (done) begin
        if (loc_q.size() == 0) report($sformatf("unexpected location %0d", location));
        else begin
          want = loc_q.pop_front();
          if (location !== want)
            report($sformatf("location got %0d want %0d", location, want));
        end
      end
      if (start && !busy) begin
        p.x = point_x; p.y = point_y; p.z = point_z;
        loc_q.push_back(locate(p));
      end
      if (cfg_valid && cfg_ready) vtx_reg[cfg_index] <= cfg_data;
    end
  end

endmodule

### bench/tb_point_in_tetrahedron_classify.sv
// Testbench top: drives points and vertex writes, gives the verdict.
`timescale 1ns / 1ps
module tb_point_in_tetrahedron_classify;
  import pitc_pkg::*;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic signed [COORD_BITS-1:0] point_x, point_y, point_z;
  logic [3:0] location;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [VTX_BITS-1:0] cfg_data;
  int fail_count, pending, cycles;
  logic [VTX_BITS-1:0] verts [4];
  logic idle_ok;

  localparam int LIMIT = 200000;
  localparam int LATENCY = 8;

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  point_in_tetrahedron_classify u_top (.*);
  pitc_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [VTX_BITS-1:0] pack(int x, int y, int z);
    coord_t cx, cy, cz;
    cx = coord_t'(x); cy = coord_t'(y); cz = coord_t'(z);
    return {cz, cy, cx};
  endfunction

  // cfg_valid is held by set_tet across the four beats
  task automatic write_vertex(reg_idx_t idx, logic [VTX_BITS-1:0] v);
    cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    verts[idx] = v;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_tet(logic [VTX_BITS-1:0] a, b, c, d);
    settle();
    cfg_valid <= 1'b1;
    write_vertex(REG_VTX0, a); write_vertex(REG_VTX1, b);
    write_vertex(REG_VTX2, c); write_vertex(REG_VTX3, d);
    cfg_valid <= 1'b0;
  endtask

  // start is left high after the beat so back-to-back points follow on
  task automatic send(int x, int y, int z);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    point_x <= coord_t'(x); point_y <= coord_t'(y); point_z <= coord_t'(z);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // point mostly near the tetrahedron: vertex, edge/face combos, or noise
  task automatic send_random(int span);
    int a, b, c, w0, w1, w2, w3, s;
    coord_t v [4][3];
    for (int k = 0; k < 4; k++) begin
      v[k][0] = verts[k][15:0]; v[k][1] = verts[k][31:16]; v[k][2] = verts[k][47:32];
    end
    case ($urandom_range(0, 5))
      0: begin
        a = $urandom_range(0, 3);
        send(v[a][0], v[a][1], v[a][2]);
      end
      1, 2, 3: begin
        w0 = $urandom_range(0, 3); w1 = $urandom_range(0, 3);
        w2 = $urandom_range(0, 3); w3 = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) w3 = 0;
        if ($urandom_range(0, 2) == 0) w2 = 0;
        s = w0 + w1 + w2 + w3;
        if (s == 0) begin w0 = 1; s = 1; end
        a = (w0 * v[0][0] + w1 * v[1][0] + w2 * v[2][0] + w3 * v[3][0]) / s;
        b = (w0 * v[0][1] + w1 * v[1][1] + w2 * v[2][1] + w3 * v[3][1]) / s;
        c = (w0 * v[0][2] + w1 * v[1][2] + w2 * v[2][2] + w3 * v[3][2]) / s;
        send(a + $urandom_range(0, 2) - 1, b + $urandom_range(0, 2) - 1, c);
      end
      4: send($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
              $urandom_range(0, 2 * span) - span);
      default: send($urandom(), $urandom(), $urandom());
    endcase
  endtask

  function automatic logic [VTX_BITS-1:0] rand_vtx(int span);
    return pack($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                $urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    int span;
    cycles = 0; rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0;
    cfg_data = '0; point_x = '0; point_y = '0; point_z = '0; idle_ok = 1'b0;
    for (int k = 0; k < 4; k++) verts[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset tetrahedron: all vertices at origin, fully degenerate
    send(0, 0, 0); send(1, 0, 0);
    set_tet(pack(0, 0, 0), pack(10, 0, 0), pack(0, 10, 0), pack(0, 0, 10));
    send(0, 0, 0); send(10, 0, 0); send(0, 10, 0); send(0, 0, 10);
    send(1, 1, 1); send(5, 0, 0); send(0, 5, 0); send(0, 0, 5);
    send(5, 5, 0); send(0, 5, 5); send(5, 0, 5);
    send(1, 1, 0); send(1, 0, 1); send(0, 1, 1); send(3, 3, 3);
    send(20, 20, 20); send(-1, 0, 0);
    // extremes of the coordinate range
    set_tet(pack(-32768, -32768, -32768), pack(32767, -32768, -32768),
            pack(-32768, 32767, -32768), pack(-32768, -32768, 32767));
    send(-32768, -32768, -32768); send(32767, 32767, 32767);
    send(0, 0, 0); send(-32768, 0, 0); send(32767, -32768, -32768);
    send(-32768, -32768, 32767);
    // coplanar tetrahedron
    set_tet(pack(0, 0, 0), pack(4, 0, 0), pack(0, 4, 0), pack(4, 4, 0));
    send(1, 1, 0); send(1, 1, 1);

    idle_ok = 1'b1;
    for (int ph = 0; ph < 24; ph++) begin
      span = (ph % 4 == 0) ? 32767 : (ph % 4 == 1) ? 200 : 20;
      if (ph == 23) idle_ok = 1'b0;
      set_tet(rand_vtx(span), rand_vtx(span), rand_vtx(span),
              (ph % 7 == 3) ? verts[0] : rand_vtx(span));
      for (int i = 0; i < 75; i++) begin
        send_random(span);
        if (i == 40 && ph == 5) settle();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
